@@ hw/rtl/sfb_pkg.sv @@
// Shared types and constants of the seam feather blender.
`default_nettype none

package sfb_pkg;

	// Fixed field widths
	localparam int CFG_W   = 13;
	localparam int COL_W   = 12;
	localparam int CH_W    = 8;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 4;

	// Restoring divide steps done in each divider stage
	localparam int DIV_STEPS = 4;

	// pi in Q30, and the Taylor term divisors (2k)(2k+1) for k = 1..6
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_OVERLAP_WIDTH = 2'd1,
		REG_ATTACH_RIGHT  = 2'd2,
		REG_SEAM_MODE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] overlap_width;
		logic             attach_right;
		logic             seam_mode;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pix_t;

	// Data that rides alongside the divider: weight saturation and the pixels
	typedef struct packed {
		logic sat_lo;
		logic sat_hi;
		pix_t base;
		pix_t canvas;
	} side_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfb_regs.sv @@
// Configuration register bank behind the APB-style port.
`default_nettype none

module sfb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sfb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [sfb_pkg::DATA_W-1:0]   pwdata,
	output logic      [sfb_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output sfb_pkg::cfg_t                     cfg
);

	sfb_pkg::cfg_t     cfg_q;
	sfb_pkg::reg_idx_t sel;
	logic              wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign sel    = sfb_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= sfb_pkg::CFG_W'(640);
			cfg_q.overlap_width <= sfb_pkg::CFG_W'(64);
			cfg_q.attach_right  <= 1'b1;
			cfg_q.seam_mode     <= 1'b0;
		end else if (wr) begin
			case (sel)
				sfb_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[sfb_pkg::CFG_W-1:0];
				sfb_pkg::REG_OVERLAP_WIDTH: cfg_q.overlap_width <= pwdata[sfb_pkg::CFG_W-1:0];
				sfb_pkg::REG_ATTACH_RIGHT:  cfg_q.attach_right  <= pwdata[0];
				sfb_pkg::REG_SEAM_MODE:     cfg_q.seam_mode     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			sfb_pkg::REG_IMAGE_WIDTH:   prdata = sfb_pkg::DATA_W'(cfg_q.image_width);
			sfb_pkg::REG_OVERLAP_WIDTH: prdata = sfb_pkg::DATA_W'(cfg_q.overlap_width);
			sfb_pkg::REG_ATTACH_RIGHT:  prdata = sfb_pkg::DATA_W'(cfg_q.attach_right);
			sfb_pkg::REG_SEAM_MODE:     prdata = sfb_pkg::DATA_W'(cfg_q.seam_mode);
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/sfb_div.sv @@
// Pipelined restoring divider: numerator over overlap width, DIV_STEPS bits a stage.
`default_nettype none

module sfb_div #(
	parameter int QT = 16,
	parameter int NW = 29
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_vld,
	input  wire logic [NW-1:0]              num,
	input  wire logic [sfb_pkg::CFG_W-1:0]  den,
	input  wire sfb_pkg::side_t             side_in,
	output logic                            out_vld,
	output logic      [QT-1:0]              quot,
	output sfb_pkg::side_t                  side_out
);

	localparam int DW = sfb_pkg::CFG_W;
	localparam int DS = QT / sfb_pkg::DIV_STEPS;

	logic [DS-1:0]   vld_s;
	logic [DW-1:0]   rem_s  [DS-1];
	logic [QT-1:0]   wq_s   [DS];
	sfb_pkg::side_t  side_s [DS];

	logic [DW-1:0]   rem_d  [DS];
	logic [QT-1:0]   wq_d   [DS];
	logic [DW-1:0]   rem_i  [DS];
	logic [QT-1:0]   wq_i   [DS];
	logic [DS-1:0]   vld_i;
	sfb_pkg::side_t  side_i [DS];

	for (genvar g = 0; g < DS; g++) begin : g_stage
		if (g == 0) begin : g_first
			// Top numerator bits are already below the divisor
			assign rem_i[g]  = num[NW-1:QT];
			assign wq_i[g]   = num[QT-1:0];
			assign vld_i[g]  = in_vld;
			assign side_i[g] = side_in;
		end else begin : g_next
			assign rem_i[g]  = rem_s[g-1];
			assign wq_i[g]   = wq_s[g-1];
			assign vld_i[g]  = vld_s[g-1];
			assign side_i[g] = side_s[g-1];
		end

		// Shift numerator bits out of the top of wq, quotient bits in at the bottom
		always_comb begin
			logic [DW-1:0] r;
			logic [QT-1:0] w;
			logic [DW:0]   t;
			r = rem_i[g];
			w = wq_i[g];
			for (int i = 0; i < sfb_pkg::DIV_STEPS; i++) begin
				t = {r, w[QT-1]};
				if (t >= {1'b0, den}) begin
					t = t - {1'b0, den};
					w = {w[QT-2:0], 1'b1};
				end else begin
					w = {w[QT-2:0], 1'b0};
				end
				r = t[DW-1:0];
			end
			rem_d[g] = r;
			wq_d[g]  = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_i[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				wq_s[g]   <= wq_d[g];
				side_s[g] <= side_i[g];
			end
		end

		if (g < DS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= rem_d[g];
				end
			end
		end
	end

	assign out_vld  = vld_s[DS-1];
	assign quot     = wq_s[DS-1];
	assign side_out = side_s[DS-1];

	// A stalled pipe keeps its occupancy
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("divider occupancy changed during a stall");

endmodule

`default_nettype wire

@@ hw/rtl/sfb_alpha.sv @@
// Canvas weight: raised-cosine ROM lookup or linear ramp, with saturation.
`default_nettype none

module sfb_alpha #(
	parameter int F  = 16,
	parameter int D  = 1024,
	parameter int QT = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           seam_mode,
	input  wire logic           in_vld,
	input  wire logic [QT-1:0]  quot,
	input  wire sfb_pkg::side_t side_in,
	output logic                out_vld,
	output logic      [F:0]     alpha,
	output sfb_pkg::side_t      side_out
);

	localparam int AW    = F + 1;
	localparam int IW    = $clog2(D + 1);
	localparam int TWO_D = 2 * D;
	localparam logic [AW-1:0] ONE = AW'(1) << F;

	// round(ONE * sin(pi*i/(2D))^2), sine from a Q30 Taylor series
	function automatic logic [AW-1:0] rc_entry(input int unsigned i);
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] mag;
		logic [63:0] s;
		logic [63:0] sq;
		longint      sum;
		y   = (sfb_pkg::PI_Q30 * 64'(i)) / 64'(TWO_D);
		y2  = (y * y) >> 30;
		mag = y;
		sum = longint'(y);
		for (int k = 1; k <= 6; k++) begin
			mag = ((mag * y2) >> 30) / 64'(sfb_pkg::TAYLOR_DIV[k-1]);
			if (k % 2 == 1) begin
				sum = sum - longint'(mag);
			end else begin
				sum = sum + longint'(mag);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(64'd1 << 30)) begin
			sum = longint'(64'd1 << 30);
		end
		s  = 64'(sum);
		sq = s * s + (64'd1 << (59 - F));
		return AW'(sq >> (60 - F));
	endfunction

	logic [AW-1:0] cos_rom [D+1];

	for (genvar gi = 0; gi <= D; gi++) begin : g_rom
		assign cos_rom[gi] = rc_entry(gi);
	end

	logic [IW-1:0]  idx;
	logic           vld_s1;
	logic [AW-1:0]  rom_s1;
	logic [F-1:0]   ramp_s1;
	sfb_pkg::side_t side_s1;
	logic           vld_s2;
	logic [AW-1:0]  alpha_s2;
	sfb_pkg::side_t side_s2;
	logic [AW-1:0]  alpha_d;

	assign idx = (quot > QT'(D)) ? IW'(D) : quot[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_s1  <= cos_rom[idx];
			ramp_s1 <= quot[F-1:0];
			side_s1 <= side_in;
		end
	end

	always_comb begin
		if (side_s1.sat_lo) begin
			alpha_d = '0;
		end else if (side_s1.sat_hi) begin
			alpha_d = ONE;
		end else if (seam_mode) begin
			alpha_d = AW'(ramp_s1);
		end else begin
			alpha_d = rom_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s2 <= alpha_d;
			side_s2  <= side_s1;
		end
	end

	assign out_vld  = vld_s2;
	assign alpha    = alpha_s2;
	assign side_out = side_s2;

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> alpha_s2 <= ONE)
		else $error("weight above one");

	a_sat_lo: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && en && side_s1.sat_lo |=> alpha_s2 == '0)
		else $error("base-only pixel got a non-zero weight");

	a_sat_hi: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && en && !side_s1.sat_lo && side_s1.sat_hi |=> alpha_s2 == ONE)
		else $error("attach-side pixel did not get full weight");

endmodule

`default_nettype wire

@@ hw/rtl/sfb_mix.sv @@
// Per-channel blend lanes: base + alpha*(canvas - base), then drop fraction.
`default_nettype none

module sfb_mix #(
	parameter int F = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire logic [F:0]     alpha,
	input  wire sfb_pkg::side_t side_in,
	output logic                out_vld,
	output sfb_pkg::pix_t       pix
);

	localparam int CW  = sfb_pkg::CH_W;
	localparam int AW  = F + 1;
	localparam int PRW = AW + CW + 2;

	logic [CW-1:0]         b_ch [3];
	logic [CW-1:0]         c_ch [3];
	logic                  vld_s1;
	logic signed [PRW-1:0] prod_s1 [3];
	logic [CW-1:0]         base_s1 [3];
	logic                  vld_s2;
	logic [CW-1:0]         res_s2 [3];

	assign b_ch[0] = side_in.base.blue;
	assign b_ch[1] = side_in.base.green;
	assign b_ch[2] = side_in.base.red;
	assign c_ch[0] = side_in.canvas.blue;
	assign c_ch[1] = side_in.canvas.green;
	assign c_ch[2] = side_in.canvas.red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic signed [CW:0]    diff;
		logic signed [PRW-1:0] sum;

		assign diff = $signed({1'b0, c_ch[ch]}) - $signed({1'b0, b_ch[ch]});
		assign sum  = $signed(PRW'({base_s1[ch], {F{1'b0}}})) + prod_s1[ch];

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[ch] <= PRW'($signed({1'b0, alpha}) * diff);
				base_s1[ch] <= b_ch[ch];
				res_s2[ch]  <= sum[F+CW-1:F];
			end
		end
	end

	assign out_vld   = vld_s2;
	assign pix.blue  = res_s2[0];
	assign pix.green = res_s2[1];
	assign pix.red   = res_s2[2];

endmodule

`default_nettype wire

@@ hw/rtl/seam_feather_blend.sv @@
// Top level of the seam feather blender: front stages and pipeline assembly.
// One pixel pair enters per clock and one blended pixel leaves per clock
// while the output beat is not stalled. The divider retires four quotient
// bits of position*scale/overlap in each of its stages; its quotient width
// QT is the larger of ALPHA_FRAC_BITS and the cosine index width, rounded
// up to a multiple of four. Around it sit two front stages (overlap
// position, then saturation and numerator), two weight stages (registered
// cosine ROM read, then weight select) and two blend stages (multiply, then
// add and output register). Pixels where one side is black skip the weight and
// pass straight through with zero weight. The whole pipe advances together: a
// stalled output beat holds every stage and raises pix_stall in the same cycle,
// so nothing is dropped or repeated. Registers sit at byte offsets 0, 4, 8, 12
// (image_width, overlap_width, attach_right, seam_mode); write them only while
// the pipe is empty.
`default_nettype none

module seam_feather_blend #(
	parameter int MAX_WIDTH       = 4096,
	parameter int ALPHA_FRAC_BITS = 16,
	parameter int COS_TABLE_DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sfb_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [sfb_pkg::DATA_W-1:0]   pwdata,
	output logic      [sfb_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	// pixel pair beats
	input  wire logic                         pix_valid,
	output logic                              pix_stall,
	input  wire logic [sfb_pkg::COL_W-1:0]    column,
	input  wire logic [sfb_pkg::CH_W-1:0]     base_blue,
	input  wire logic [sfb_pkg::CH_W-1:0]     base_green,
	input  wire logic [sfb_pkg::CH_W-1:0]     base_red,
	input  wire logic [sfb_pkg::CH_W-1:0]     canvas_blue,
	input  wire logic [sfb_pkg::CH_W-1:0]     canvas_green,
	input  wire logic [sfb_pkg::CH_W-1:0]     canvas_red,
	// blended pixel beats
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic      [sfb_pkg::CH_W-1:0]     out_blue,
	output logic      [sfb_pkg::CH_W-1:0]     out_green,
	output logic      [sfb_pkg::CH_W-1:0]     out_red
);

	localparam int CW  = sfb_pkg::CFG_W;
	localparam int PW  = CW + 2;
	localparam int F   = ALPHA_FRAC_BITS;
	localparam int IW  = $clog2(COS_TABLE_DEPTH + 1);
	localparam int QB  = (F > IW) ? F : IW;
	localparam int DS  = (QB + sfb_pkg::DIV_STEPS - 1) / sfb_pkg::DIV_STEPS;
	localparam int QT  = DS * sfb_pkg::DIV_STEPS;
	localparam int NW  = CW + QT;

	sfb_pkg::cfg_t cfg;

	sfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Whole pipe moves unless the output beat is held
	logic en;
	assign en        = !(res_valid && res_stall);
	assign pix_stall = !en;

	// User keeps registers static with items in flight, unchecked; clamp them once
	logic [CW-1:0] w_c;
	logic [CW-1:0] ov_c;
	logic [CW-1:0] ov_sat;

	assign w_c    = (32'(cfg.image_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : cfg.image_width;
	assign ov_sat = (32'(cfg.overlap_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : cfg.overlap_width;
	assign ov_c   = (ov_sat == '0) ? CW'(1) : ov_sat;

	// ---- stage 1: overlap position and black-pixel routing ----
	sfb_pkg::pix_t     base_in;
	sfb_pkg::pix_t     canvas_in;
	logic              base_black;
	logic              canvas_black;
	logic              blend;
	logic signed [PW-1:0] col_x;
	logic signed [PW-1:0] w_x;
	logic signed [PW-1:0] ov_x;
	logic signed [PW-1:0] p_d;

	assign base_in.blue    = base_blue;
	assign base_in.green   = base_green;
	assign base_in.red     = base_red;
	assign canvas_in.blue  = canvas_blue;
	assign canvas_in.green = canvas_green;
	assign canvas_in.red   = canvas_red;

	assign base_black   = ~|{base_blue, base_green, base_red};
	assign canvas_black = ~|{canvas_blue, canvas_green, canvas_red};
	assign blend        = !base_black && !canvas_black;

	assign col_x = $signed(PW'(column));
	assign w_x   = $signed(PW'(w_c));
	assign ov_x  = $signed(PW'(ov_c));
	// count from the base-only side, mirrored by the attach side
	assign p_d   = cfg.attach_right ? (col_x - (w_x - ov_x)) : (ov_x - col_x);

	logic                 vld_s1;
	logic                 blend_s1;
	logic signed [PW-1:0] p_s1;
	sfb_pkg::pix_t        base_s1;
	sfb_pkg::pix_t        canvas_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
		end
	end

	// A non-blended pixel rides as the base with zero weight: base passes when
	// the canvas is black, the canvas passes when only the base is black
	always_ff @(posedge clk) begin
		if (en) begin
			blend_s1  <= blend;
			p_s1      <= p_d;
			base_s1   <= (blend || canvas_black) ? base_in : canvas_in;
			canvas_s1 <= canvas_in;
		end
	end

	// ---- stage 2: saturation and divider numerator ----
	logic            le0;
	logic            ge_ov;
	logic [CW-1:0]   p_mid;
	logic [NW-1:0]   num_d;
	sfb_pkg::side_t  side_d;

	assign le0   = p_s1[PW-1] || (p_s1 == '0);
	assign ge_ov = (p_s1 >= ov_x);
	assign p_mid = p_s1[CW-1:0];

	// ramp: p*2^F/ov; cosine index: round(p*DEPTH/ov)
	assign num_d = cfg.seam_mode ? (NW'(p_mid) << F)
	                             : (NW'(p_mid) * NW'(COS_TABLE_DEPTH) + NW'(ov_c >> 1));

	assign side_d.sat_lo = !blend_s1 || le0;
	assign side_d.sat_hi = ge_ov;
	assign side_d.base   = base_s1;
	assign side_d.canvas = canvas_s1;

	logic           vld_s2;
	logic [NW-1:0]  num_s2;
	sfb_pkg::side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= num_d;
			side_s2 <= side_d;
		end
	end

	// ---- divider ----
	logic           div_vld;
	logic [QT-1:0]  div_quot;
	sfb_pkg::side_t div_side;

	sfb_div #(
		.QT (QT),
		.NW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.num      (num_s2),
		.den      (ov_c),
		.side_in  (side_s2),
		.out_vld  (div_vld),
		.quot     (div_quot),
		.side_out (div_side)
	);

	// ---- weight ----
	logic           wt_vld;
	logic [F:0]     wt_alpha;
	sfb_pkg::side_t wt_side;

	sfb_alpha #(
		.F  (F),
		.D  (COS_TABLE_DEPTH),
		.QT (QT)
	) u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.seam_mode (cfg.seam_mode),
		.in_vld    (div_vld),
		.quot      (div_quot),
		.side_in   (div_side),
		.out_vld   (wt_vld),
		.alpha     (wt_alpha),
		.side_out  (wt_side)
	);

	// ---- blend and output register ----
	sfb_pkg::pix_t res_pix;

	sfb_mix #(
		.F (F)
	) u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (wt_vld),
		.alpha   (wt_alpha),
		.side_in (wt_side),
		.out_vld (res_valid),
		.pix     (res_pix)
	);

	assign out_blue  = res_pix.blue;
	assign out_green = res_pix.green;
	assign out_red   = res_pix.red;

endmodule

`default_nettype wire

@@ sim/seam_feather_blend_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the seam feather blender: directed and random pixel pairs.
module seam_feather_blend_test;

	// Block parameters as built, and the Q30 unit of the sine series
	localparam int MAX_W = 4096;
	localparam int FRAC = 16;
	localparam int DEPTH = 1024;
	localparam longint unsigned ALPHA_ONE = 64'd1 << FRAC;
	localparam longint SINE_ONE = 64'sd1073741824;

	// Quiet cycles after draining before a register write (pipe is ~10 deep),
	// cycles with no beat at all before giving up, and the shape of the random run
	localparam int SETTLE = 16;
	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_BEATS = 60;

	// One blended pixel still owed by the block, with its column for messages
	typedef struct {
		sfb_pkg::pix_t             pix;
		logic [sfb_pkg::COL_W-1:0] col;
	} blended_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [sfb_pkg::PADDR_W-1:0] paddr;
	logic [sfb_pkg::DATA_W-1:0]  pwdata;
	logic [sfb_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	logic                        pix_valid;
	logic                        pix_stall;
	logic [sfb_pkg::COL_W-1:0]   column;
	logic [sfb_pkg::CH_W-1:0]    base_blue;
	logic [sfb_pkg::CH_W-1:0]    base_green;
	logic [sfb_pkg::CH_W-1:0]    base_red;
	logic [sfb_pkg::CH_W-1:0]    canvas_blue;
	logic [sfb_pkg::CH_W-1:0]    canvas_green;
	logic [sfb_pkg::CH_W-1:0]    canvas_red;
	logic                        res_valid;
	logic                        res_stall = 1'b0;
	logic [sfb_pkg::CH_W-1:0]    out_blue;
	logic [sfb_pkg::CH_W-1:0]    out_green;
	logic [sfb_pkg::CH_W-1:0]    out_red;

	// Our own copy of the registers, the raised-cosine weights and the pixels in flight
	sfb_pkg::cfg_t   feather_cfg;
	longint unsigned cosine_rom [0:DEPTH];
	blended_t        blended_q [$];
	int              errors;
	int              idle_pct;
	int              stall_pct;

	seam_feather_blend dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.column       (column),
		.base_blue    (base_blue),
		.base_green   (base_green),
		.base_red     (base_red),
		.canvas_blue  (canvas_blue),
		.canvas_green (canvas_green),
		.canvas_red   (canvas_red),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Fill the weight table: sin^2 of a quarter turn, the sine taken from its
	// Taylor series in Q30 with each term floored from the one before it, the
	// sum clamped to [0, 1] and the square rounded to FRAC fraction bits.
	function automatic void build_cosine_rom();
		longint unsigned angle, angle_sq, term, sine;
		longint          sum;
		for (longint unsigned i = 0; i <= DEPTH; i++) begin
			angle    = (sfb_pkg::PI_Q30 * i) / (2 * DEPTH);
			angle_sq = (angle * angle) >> 30;
			term     = angle;
			sum      = longint'(angle);
			for (longint unsigned k = 1; k <= 6; k++) begin
				term = ((term * angle_sq) >> 30) / ((2 * k) * (2 * k + 1));
				if (k[0]) begin
					sum -= longint'(term);
				end else begin
					sum += longint'(term);
				end
			end
			if (sum < 0) sum = 0;
			if (sum > SINE_ONE) sum = SINE_ONE;
			sine = sum;
			cosine_rom[i] = (sine * sine + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
		end
	endfunction

	// Canvas weight for a column: position into the overlap counted from the
	// base-only side, zero before it, full weight past it, ramp or table inside.
	function automatic longint unsigned feather_weight(logic [sfb_pkg::COL_W-1:0] col);
		longint img_w, ovl, pos, idx;
		img_w = (feather_cfg.image_width > MAX_W) ? MAX_W : longint'(feather_cfg.image_width);
		ovl   = (feather_cfg.overlap_width > MAX_W) ? MAX_W : longint'(feather_cfg.overlap_width);
		// a zero overlap behaves as a hard seam one pixel wide
		if (ovl < 1) ovl = 1;
		if (feather_cfg.attach_right) begin
			pos = longint'(col) - (img_w - ovl);
		end else begin
			pos = ovl - longint'(col);
		end
		if (pos <= 0) return 0;
		if (pos >= ovl) return ALPHA_ONE;
		if (feather_cfg.seam_mode) return (pos << FRAC) / ovl;
		idx = (pos * DEPTH + ovl / 2) / ovl;
		if (idx > DEPTH) idx = DEPTH;
		return cosine_rom[idx];
	endfunction

	function automatic logic [sfb_pkg::CH_W-1:0] mix_channel(longint unsigned alpha,
	                                                         logic [sfb_pkg::CH_W-1:0] canvas_ch,
	                                                         logic [sfb_pkg::CH_W-1:0] base_ch);
		longint unsigned acc;
		acc = alpha * canvas_ch + (ALPHA_ONE - alpha) * base_ch;
		return sfb_pkg::CH_W'(acc >> FRAC);
	endfunction

	// Blend only where both sides carry something; a black canvas lets the
	// base through, any other black leaves the canvas as it is.
	function automatic sfb_pkg::pix_t blend_pixel(logic [sfb_pkg::COL_W-1:0] col,
	                                              sfb_pkg::pix_t base,
	                                              sfb_pkg::pix_t canvas);
		longint unsigned alpha;
		sfb_pkg::pix_t   mix;
		if (base != '0 && canvas != '0) begin
			alpha     = feather_weight(col);
			mix.blue  = mix_channel(alpha, canvas.blue, base.blue);
			mix.green = mix_channel(alpha, canvas.green, base.green);
			mix.red   = mix_channel(alpha, canvas.red, base.red);
			return mix;
		end
		if (canvas == '0) return base;
		return canvas;
	endfunction

	task automatic set_idling(int send_idle, int recv_stall);
		idle_pct  = send_idle;
		stall_pct = recv_stall;
	endtask

	// Drop valid and hold until every blended pixel is back; optionally let the
	// pipe run quiet for a while so that nothing is left in flight.
	task automatic hold_until_drained(bit settle);
		@(negedge clk);
		pix_valid <= 1'b0;
		while (blended_q.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge where the access phase sees pready.
	task automatic write_register(sfb_pkg::reg_idx_t idx, logic [sfb_pkg::CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sfb_pkg::PADDR_W'({idx, 2'b00});
		pwdata  <= sfb_pkg::DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			sfb_pkg::REG_IMAGE_WIDTH: begin
				feather_cfg.image_width = value;
			end
			sfb_pkg::REG_OVERLAP_WIDTH: begin
				feather_cfg.overlap_width = value;
			end
			sfb_pkg::REG_ATTACH_RIGHT: begin
				feather_cfg.attach_right = value[0];
			end
			sfb_pkg::REG_SEAM_MODE: begin
				feather_cfg.seam_mode = value[0];
			end
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(int img_w, int ovl, bit right, bit linear);
		hold_until_drained(1'b1);
		write_register(sfb_pkg::REG_IMAGE_WIDTH, sfb_pkg::CFG_W'(img_w));
		write_register(sfb_pkg::REG_OVERLAP_WIDTH, sfb_pkg::CFG_W'(ovl));
		write_register(sfb_pkg::REG_ATTACH_RIGHT, sfb_pkg::CFG_W'(right));
		write_register(sfb_pkg::REG_SEAM_MODE, sfb_pkg::CFG_W'(linear));
	endtask

	// Offer one pixel pair, idling first at the sender's rate, and note the
	// blended pixel it owes once the beat is taken. Valid stays high after the
	// beat so that back-to-back pairs need no extra assignment.
	task automatic send_pixel(logic [sfb_pkg::COL_W-1:0] col, sfb_pkg::pix_t base,
	                          sfb_pkg::pix_t canvas);
		blended_t owed;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			pix_valid <= 1'b0;
		end
		@(negedge clk);
		pix_valid    <= 1'b1;
		column       <= col;
		base_blue    <= base.blue;
		base_green   <= base.green;
		base_red     <= base.red;
		canvas_blue  <= canvas.blue;
		canvas_green <= canvas.green;
		canvas_red   <= canvas.red;
		do @(posedge clk); while (!(pix_valid && !pix_stall));
		owed.pix  = blend_pixel(col, base, canvas);
		owed.col  = col;
		blended_q = {blended_q, owed};
	endtask

	// Registers as they come out of reset: 640 wide, 64 overlap, right, cosine.
	// Walk across the seam from the base-only side to the attach side.
	task automatic test_reset_values();
		sfb_pkg::pix_t base, canvas;
		base   = '{8'hff, 8'h80, 8'h00};
		canvas = '{8'h00, 8'h7f, 8'hff};
		send_pixel(12'd0, base, canvas);
		send_pixel(12'd576, base, canvas);
		send_pixel(12'd577, base, canvas);
		send_pixel(12'd608, base, canvas);
		send_pixel(12'd639, base, canvas);
		send_pixel(12'd640, base, canvas);
		send_pixel(12'd4095, base, canvas);
	endtask

	// Black on either side, on both, and a base that is black but for one bit.
	task automatic test_black_pixels();
		send_pixel(12'd600, '0, '0);
		send_pixel(12'd600, '{8'h12, 8'h34, 8'h56}, '0);
		send_pixel(12'd600, '0, '{8'hab, 8'hcd, 8'hef});
		send_pixel(12'd600, '{8'h01, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'hff});
	endtask

	// Register extremes: a one-pixel image with zero overlap, widths beyond the
	// maximum, a full-width overlap on either side, both weight curves.
	task automatic test_config_extremes();
		sfb_pkg::pix_t base, canvas;
		base   = '{8'hff, 8'hff, 8'hff};
		canvas = '{8'h01, 8'h01, 8'h01};
		configure(1, 0, 1'b0, 1'b1);
		send_pixel(12'd0, base, canvas);
		send_pixel(12'd1, base, canvas);
		configure(8191, 8191, 1'b1, 1'b0);
		send_pixel(12'd0, base, canvas);
		send_pixel(12'd2048, base, canvas);
		send_pixel(12'd4095, canvas, base);
		configure(4096, 4096, 1'b1, 1'b1);
		send_pixel(12'd1, base, canvas);
		send_pixel(12'd4095, base, canvas);
		configure(4096, 4096, 1'b0, 1'b0);
		send_pixel(12'd0, base, canvas);
		send_pixel(12'd4095, base, canvas);
		send_pixel(12'd2047, canvas, base);
	endtask

	// Random settings per phase, half the columns aimed into the overlap, three
	// tenths of the pairs with black on one or both sides. The idling pattern
	// rotates through none, sender only, receiver only, and both.
	task automatic test_random_streams();
		int                        img_w, ovl, img_eff, ovl_eff, lo, pos;
		bit                        right;
		logic [sfb_pkg::COL_W-1:0] col;
		sfb_pkg::pix_t             base, canvas;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(7))
				0: img_w = $urandom_range(1);
				1: img_w = MAX_W;
				2: img_w = $urandom_range(8191, MAX_W + 1);
				default: img_w = $urandom_range(MAX_W, 1);
			endcase
			case ($urandom_range(7))
				0: ovl = 0;
				1: ovl = 1;
				2: ovl = $urandom_range(8191, MAX_W);
				3: ovl = img_w;
				default: ovl = $urandom_range((img_w > 1) ? img_w : 1, 1);
			endcase
			right = 1'($urandom_range(1));
			configure(img_w, ovl, right, 1'($urandom_range(1)));
			case (ph % 4)
				0: set_idling(0, 0);
				1: set_idling(56, 0);
				2: set_idling(0, 56);
				default: set_idling(23, 23);
			endcase
			img_eff = (img_w > MAX_W) ? MAX_W : img_w;
			ovl_eff = (ovl > MAX_W) ? MAX_W : ((ovl < 1) ? 1 : ovl);
			lo      = right ? img_eff - ovl_eff : 0;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// hold the sender back once until the pipe has emptied
				if (ph == 1 && n == PHASE_BEATS / 2) hold_until_drained(1'b0);
				if ($urandom_range(1)) begin
					pos = lo + int'($urandom_range(ovl_eff));
					if (pos < 0) pos = 0;
					if (pos > 4095) pos = 4095;
					col = sfb_pkg::COL_W'(pos);
				end else begin
					col = sfb_pkg::COL_W'($urandom);
				end
				base   = 24'($urandom);
				canvas = 24'($urandom);
				case ($urandom_range(9))
					0: base = '0;
					1: canvas = '0;
					2: begin
						base   = '0;
						canvas = '0;
					end
					default: ;
				endcase
				send_pixel(col, base, canvas);
			end
		end
	endtask

	// Receiver: stall at the current rate, decided at each falling edge
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic check_channel(string name, logic [sfb_pkg::COL_W-1:0] col,
	                             logic [sfb_pkg::CH_W-1:0] want,
	                             logic [sfb_pkg::CH_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s wrong for column %0d: expected %0d, got %0d",
			         $time, name, col, want, got);
		end
	endtask

	// Compare every blended pixel beat with the oldest one owed
	always @(posedge clk) begin
		blended_t want;
		if (res_valid && !res_stall) begin
			if (blended_q.size() == 0) begin
				errors++;
				$display("%0t: blended pixel with none owed: %0d %0d %0d",
				         $time, out_blue, out_green, out_red);
			end else begin
				want = blended_q.pop_front();
				check_channel("out_blue", want.col, want.pix.blue, out_blue);
				check_channel("out_green", want.col, want.pix.green, out_green);
				check_channel("out_red", want.col, want.pix.red, out_red);
			end
		end
	end

	// Give up when neither side has moved a beat for too long
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("%0t: no beat for %0d cycles, %0d pixels still owed",
		         $time, STUCK_LIMIT, blended_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_valid    = 1'b0;
		column       = '0;
		base_blue    = '0;
		base_green   = '0;
		base_red     = '0;
		canvas_blue  = '0;
		canvas_green = '0;
		canvas_red   = '0;
		errors       = 0;
		feather_cfg  = '{image_width: 13'd640, overlap_width: 13'd64,
		                 attach_right: 1'b1, seam_mode: 1'b0};
		set_idling(0, 0);
		build_cosine_rom();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_black_pixels();
		test_config_extremes();
		test_random_streams();

		// let the last beats out, then watch for strays
		hold_until_drained(1'b1);
		if (errors == 0 && blended_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
